FILE: hw/rtl/wofd_pkg.sv
// ----------------------------------------------------------------------------
// Wheel odometry frame decoder package
// Shared constants, widths and result codes for the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wofd_pkg;

    // Byte and field widths.
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int MAG_W       = 11;
    localparam int DELTA_W     = 12;
    localparam int TOTAL_OUT_W = 32;

    // Stream payload widths (tdata padded to whole bytes).
    localparam int OUT_FIELDS_W = COUNT_W + 2 * DELTA_W + 2 * TOTAL_OUT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + BYTE_W - 1) / BYTE_W) * BYTE_W;
    localparam int KIND_W       = 2;

    // Parameter defaults.
    localparam int DEF_MAX_FRAME_BYTES = 10;
    localparam int DEF_TOTAL_WIDTH     = 32;

    // Frame layout.
    localparam logic [BYTE_W-1:0]  TERMINATOR     = 8'hFF;
    localparam logic [COUNT_W-1:0] ODOM_FRAME_LEN = 4'd8;
    localparam logic [COUNT_W-1:0] SIGN_POS       = 4'd3;
    localparam logic [COUNT_W-1:0] LEFT_LO_POS    = 4'd4;
    localparam logic [COUNT_W-1:0] RIGHT_LO_POS   = 4'd5;

    // Bits of the sign byte.
    localparam int LEFT_POS_BIT  = 0;
    localparam int RIGHT_NEG_BIT = 1;
    localparam int LEFT_HI_LSB   = 5;
    localparam int RIGHT_HI_LSB  = 2;
    localparam int HI_W          = 3;

    // Result codes.
    typedef enum logic [KIND_W-1:0] {
        KIND_ODOM    = 2'd0,
        KIND_OTHER   = 2'd1,
        KIND_DISCARD = 2'd2
    } t_frame_kind;

endpackage : wofd_pkg

`default_nettype wire

FILE: hw/rtl/wheel_odometry_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// Wheel odometry frame decoder
// Cuts received bytes into 0xFF-terminated frames (cut at MAX_FRAME_BYTES) and
// accumulates the wheel increments of 8-byte frames into two wrapping totals.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Request carries
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | one received byte
//  m_axis   | out       | one result per ended frame (kind, length, deltas,
//           |           | totals)
//
//  A byte is taken in every cycle while results are drained. A byte is decoded
//  from the input register and its result, if any, is loaded at the next edge
//  into the queue head, or behind an earlier result in the skid entry.
//  Reset clears the byte count, the totals and all valid flags.
//  A two-entry result queue lets input continue while a result waits; the
//  input stalls when at least two of the input register and the queue entries
//  are occupied and the head is not taken in that cycle, or all three are.
//
`default_nettype none

module wheel_odometry_frame_decoder_unit
    import wofd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
    parameter int TOTAL_WIDTH     = DEF_TOTAL_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input stream.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [3:0] frame_length, [15:4] left_delta, [27:16] right_delta,
    // [59:28] left_total, [91:60] right_total, [95:92] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic [KIND_W-1:0]           m_axis_tuser    // [1:0] frame_kind
);

    localparam logic [COUNT_W-1:0] MAX_LEN = COUNT_W'(MAX_FRAME_BYTES);
    localparam int                 PAD_W   = OUT_TDATA_W - OUT_FIELDS_W;

    // Input register.
    logic                    r_in_vld;
    logic [BYTE_W-1:0]       r_in_byte;

    // Frame state.
    logic [COUNT_W-1:0]      r_count,   n_count;
    logic [BYTE_W-1:0]       r_sign,    n_sign;
    logic [BYTE_W-1:0]       r_left_lo, n_left_lo;
    logic [BYTE_W-1:0]       r_right_lo, n_right_lo;
    logic signed [TOTAL_WIDTH-1:0] r_left_sum,  n_left_sum;
    logic signed [TOTAL_WIDTH-1:0] r_right_sum, n_right_sum;

    // Result queue: head and skid entries.
    logic                    r_out_vld,  n_out_vld;
    logic [OUT_TDATA_W-1:0]  r_out_data, n_out_data;
    logic [KIND_W-1:0]       r_out_kind, n_out_kind;
    logic                    r_skid_vld,  n_skid_vld;
    logic [OUT_TDATA_W-1:0]  r_skid_data, n_skid_data;
    logic [KIND_W-1:0]       r_skid_kind, n_skid_kind;

    // Decode signals.
    logic [COUNT_W-1:0]      len;
    logic                    res_vld;
    t_frame_kind             kind;
    logic [MAG_W-1:0]        left_mag, right_mag;
    logic signed [DELTA_W-1:0] left_delta, right_delta;
    logic [OUT_TDATA_W-1:0]  res_data;
    logic                    push, pop;
    logic [1:0]              occ;

    // Accept a byte when the queue can still absorb everything in flight.
    always_comb begin
        occ           = 2'(r_out_vld) + 2'(r_skid_vld) + 2'(r_in_vld);
        pop           = r_out_vld && m_axis_tready;
        s_axis_tready = (occ <= (2'd1 + 2'(pop)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= s_axis_tvalid && s_axis_tready;
        end
        r_in_byte <= s_axis_tdata;
    end

    // Frame decode and total update for the byte in the input register.
    always_comb begin
        n_count     = r_count;
        n_sign      = r_sign;
        n_left_lo   = r_left_lo;
        n_right_lo  = r_right_lo;
        n_left_sum  = r_left_sum;
        n_right_sum = r_right_sum;
        res_vld     = 1'b0;
        kind        = KIND_OTHER;
        len         = r_count + COUNT_W'(1);

        left_mag  = {r_sign[LEFT_HI_LSB +: HI_W], r_left_lo};
        right_mag = {r_sign[RIGHT_HI_LSB +: HI_W], r_right_lo};
        left_delta  = DELTA_W'(0);
        right_delta = DELTA_W'(0);

        if (r_in_vld) begin
            // Capture the sign byte and both low bytes at their positions.
            if (r_count == SIGN_POS) begin
                n_sign = r_in_byte;
            end else if (r_count == LEFT_LO_POS) begin
                n_left_lo = r_in_byte;
            end else if (r_count == RIGHT_LO_POS) begin
                n_right_lo = r_in_byte;
            end

            if (len >= MAX_LEN) begin
                res_vld = 1'b1;
                kind    = KIND_DISCARD;
            end else if (r_in_byte == TERMINATOR) begin
                res_vld = 1'b1;
                kind    = (len == ODOM_FRAME_LEN) ? KIND_ODOM : KIND_OTHER;
            end

            if (res_vld) begin
                n_count = '0;
            end else begin
                n_count = len;
            end

            // An odometry frame applies both signed increments.
            if (res_vld && (kind == KIND_ODOM)) begin
                left_delta  = r_sign[LEFT_POS_BIT]
                            ? $signed({1'b0, left_mag})
                            : -$signed({1'b0, left_mag});
                right_delta = r_sign[RIGHT_NEG_BIT]
                            ? -$signed({1'b0, right_mag})
                            : $signed({1'b0, right_mag});
                n_left_sum  = r_left_sum  + TOTAL_WIDTH'(left_delta);
                n_right_sum = r_right_sum + TOTAL_WIDTH'(right_delta);
            end
        end

        res_data = {PAD_W'(0),
                    TOTAL_OUT_W'(n_right_sum),
                    TOTAL_OUT_W'(n_left_sum),
                    right_delta,
                    left_delta,
                    len};
        push = r_in_vld && res_vld;
    end

    // Two-entry result queue.
    always_comb begin
        n_out_vld   = r_out_vld;
        n_out_data  = r_out_data;
        n_out_kind  = r_out_kind;
        n_skid_vld  = r_skid_vld;
        n_skid_data = r_skid_data;
        n_skid_kind = r_skid_kind;

        if (pop || !r_out_vld) begin
            if (r_skid_vld) begin
                n_out_vld   = 1'b1;
                n_out_data  = r_skid_data;
                n_out_kind  = r_skid_kind;
                n_skid_vld  = push;
                n_skid_data = res_data;
                n_skid_kind = kind;
            end else begin
                n_out_vld  = push;
                n_out_data = res_data;
                n_out_kind = kind;
            end
        end else if (push) begin
            n_skid_vld  = 1'b1;
            n_skid_data = res_data;
            n_skid_kind = kind;
        end
    end

    // State and queue registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sign      <= '0;
            r_left_lo   <= '0;
            r_right_lo  <= '0;
            r_left_sum  <= '0;
            r_right_sum <= '0;
            r_out_vld   <= 1'b0;
            r_skid_vld  <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_sign      <= n_sign;
            r_left_lo   <= n_left_lo;
            r_right_lo  <= n_right_lo;
            r_left_sum  <= n_left_sum;
            r_right_sum <= n_right_sum;
            r_out_vld   <= n_out_vld;
            r_skid_vld  <= n_skid_vld;
        end
        r_out_data  <= n_out_data;
        r_out_kind  <= n_out_kind;
        r_skid_data <= n_skid_data;
        r_skid_kind <= n_skid_kind;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

endmodule : wheel_odometry_frame_decoder_unit

`default_nettype wire
